// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true at a rising edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: src/edf_pkg.sv
// ---------------------------------------------------------------------------
// edf_pkg
// shared types and constants of the edf task scheduler
// ---------------------------------------------------------------------------
package edf_pkg;

  localparam int EDF_TASKS = 16;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_SELECT = 2'd2,
    KIND_RAN    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [3:0]   slot;
    logic [15:0]  period;
    logic [15:0]  budget;
    logic [31:0]  spawn_stamp;
  } req_t;

  typedef struct packed {
    logic         found;
    logic [3:0]   chosen;
  } rsp_t;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic         have;
    logic [15:0]  countdown;
    logic [31:0]  stamp;
    logic [3:0]   chosen;
  } cand_t;

  // update broadcast to every cell
  typedef struct packed {
    logic         add;
    logic         tick;
    logic         ran;
    logic [15:0]  period;
    logic [15:0]  budget;
    logic [31:0]  stamp;
  } cell_cmd_t;

endpackage

// File: src/edf_cell.sv
// ---------------------------------------------------------------------------
// edf_cell
// one task slot: holds the task and passes on the better select candidate
// ---------------------------------------------------------------------------
module edf_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  edf_pkg::cell_cmd_t cmd,
  input  logic              sel,
  input  edf_pkg::cand_t    cand_in,
  input  logic              tok_in,
  output edf_pkg::cand_t    cand_out,
  output logic              tok_out
);
  import edf_pkg::*;

  logic        valid;
  logic [15:0] period;
  logic [15:0] budget;
  logic [15:0] cd;
  logic [15:0] runs;
  logic [31:0] stamp;

  logic runnable;
  logic take;

  assign runnable = valid && (runs < budget);
  assign take = runnable && (!cand_in.have || (cd < cand_in.countdown) ||
                ((cd == cand_in.countdown) && (stamp <= cand_in.stamp)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.add && sel) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && sel) begin
      period <= cmd.period;
      budget <= cmd.budget;
      stamp  <= cmd.stamp;
      cd     <= cmd.period;
      runs   <= 16'd0;
    end else if (cmd.tick && valid) begin
      if (cd == 16'd0) begin
        cd   <= period;
        runs <= 16'd0;
      end else begin
        cd <= cd - 16'd1;
      end
    end else if (cmd.ran && sel && valid && (runs != 16'hFFFF)) begin
      runs <= runs + 16'd1;
    end
  end

  // candidate chain stage
  always_ff @(posedge clk) begin
    if (take) begin
      cand_out.have      <= 1'b1;
      cand_out.countdown <= cd;
      cand_out.stamp     <= stamp;
      cand_out.chosen    <= 4'(IDX);
    end else begin
      cand_out <= cand_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

endmodule

// File: src/edf_task_scheduler.sv
// ---------------------------------------------------------------------------
// edf_task_scheduler
// earliest-deadline-first scheduler over a row of task cells
// ---------------------------------------------------------------------------
// add, tick and ran: result in the cycle after the request is accepted
// select: result once the select token, launched at acceptance, has walked
//   the chain of TASKS cells, one cell per cycle
// one request at a time: the next request is taken the cycle after its result
// reset clears valid bits and control at once; no clearing pass
// results are single-cycle done pulses; the receiver cannot stall
module edf_task_scheduler #(
  parameter int TASKS = edf_pkg::EDF_TASKS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  edf_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output edf_pkg::rsp_t result
);
  import edf_pkg::*;

  logic      accept;
  cell_cmd_t cmd;
  logic      simple_done;

  // token and candidate chain, entry 0 feeds the first cell
  logic [TASKS:0] tok;
  cand_t          cand [TASKS+1];
  logic [TASKS-1:0] sel;

  assign accept = start && !busy;

  // updates are broadcast to every cell and take effect at the accept edge
  assign cmd.add    = accept && (request.kind == KIND_ADD);
  assign cmd.tick   = accept && (request.kind == KIND_TICK);
  assign cmd.ran    = accept && (request.kind == KIND_RAN);
  assign cmd.period = request.period;
  assign cmd.budget = request.budget;
  assign cmd.stamp  = request.spawn_stamp;

  // select launches a token with an empty candidate into the first cell
  assign tok[0]  = accept && (request.kind == KIND_SELECT);
  assign cand[0] = '0;

  for (genvar i = 0; i < TASKS; i++) begin : g_cell
    // slots at or above TASKS match no cell and are dropped
    assign sel[i] = (32'(request.slot) == 32'(i));

    edf_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sel      (sel[i]),
      .cand_in  (cand[i]),
      .tok_in   (tok[i]),
      .cand_out (cand[i+1]),
      .tok_out  (tok[i+1])
    );
  end

  // busy from acceptance until the result pulse has gone out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      simple_done <= 1'b0;
    end else begin
      simple_done <= accept && (request.kind != KIND_SELECT);
      if (accept) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // select answers when the token leaves the last cell
  assign done          = simple_done || tok[TASKS];
  assign result.found  = tok[TASKS] && cand[TASKS].have;
  assign result.chosen = result.found ? cand[TASKS].chosen : 4'd0;

`include "assert_macros.svh"

  // a result only appears while a request is outstanding
  `ASSERT_CLK(a_done_busy, done |-> busy, "result without outstanding request")
  // results are isolated single-cycle pulses
  `ASSERT_CLK(a_done_pulse, done |=> !done, "result pulse longer than one cycle")
  // at most one select token in flight, never together with a simple result
  `ASSERT_CLK(a_one_token, $onehot0({simple_done, tok[TASKS:1]}), "multiple tokens in flight")
  // no request may be taken while a token walks the chain
  `ASSERT_NEVER(a_no_accept, accept && (tok[TASKS:1] != '0), "request accepted during select")

endmodule

// File: dv/edf_task_scheduler_test.sv
// ---------------------------------------------------------------------------
// edf_task_scheduler_test
// self-checking bench for the earliest-deadline-first task scheduler: a
// directed table and a random mix of add, tick, select and ran requests,
// every result compared with a hand-written answer or a local model
// ---------------------------------------------------------------------------
module edf_task_scheduler_test;
  import edf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1925;
  localparam int DRAIN_CYCLES    = EDF_TASKS + 8;   // select walks every cell
  localparam int STALL_LIMIT     = 4000;            // idle cycles before giving up
  localparam int REPORT_LIMIT    = 10;

  logic  clk;
  logic  rst;
  logic  start;
  req_t  request;
  logic  busy;
  logic  done;
  rsp_t  result;

  edf_task_scheduler #(.TASKS(EDF_TASKS)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // local copy of the task table
  logic        tbl_valid  [EDF_TASKS];
  logic [15:0] tbl_period [EDF_TASKS];
  logic [15:0] tbl_budget [EDF_TASKS];
  logic [15:0] tbl_count  [EDF_TASKS];
  logic [15:0] tbl_runs   [EDF_TASKS];
  logic [31:0] tbl_stamp  [EDF_TASKS];

  rsp_t expected_picks [$];

  // one row of the directed table; pinned rows carry a hand-written answer
  typedef struct {
    req_t req;
    bit   pinned;
    rsp_t rsp;
  } plan_row_t;

  plan_row_t plan [$];

  int fail_count;
  int mismatch_count;
  int accepted;
  int picks_found;
  int idle_cycles;
  int burst_left;

  // applies one request to the local table and returns the answer it implies
  function automatic rsp_t schedule_step(input req_t r);
    rsp_t        o;
    logic        have;
    int          best;
    int          i;
    o    = '0;
    have = 1'b0;
    best = 0;
    case (r.kind)
      KIND_ADD: begin
        tbl_valid[r.slot]  = 1'b1;
        tbl_period[r.slot] = r.period;
        tbl_budget[r.slot] = r.budget;
        tbl_count[r.slot]  = r.period;
        tbl_runs[r.slot]   = '0;
        tbl_stamp[r.slot]  = r.spawn_stamp;
      end
      KIND_TICK: begin
        for (i = 0; i < EDF_TASKS; i++) begin
          if (tbl_valid[i]) begin
            // an expired deadline starts a fresh period with a clean run count
            if (tbl_count[i] == '0) begin
              tbl_count[i] = tbl_period[i];
              tbl_runs[i]  = '0;
            end else begin
              tbl_count[i] = tbl_count[i] - 16'd1;
            end
          end
        end
      end
      KIND_SELECT: begin
        for (i = 0; i < EDF_TASKS; i++) begin
          if (tbl_valid[i] && tbl_runs[i] < tbl_budget[i]) begin
            // later slots win full ties, hence <= on the stamp
            if (!have || tbl_count[i] < tbl_count[best] ||
                (tbl_count[i] == tbl_count[best] && tbl_stamp[i] <= tbl_stamp[best])) begin
              best = i;
              have = 1'b1;
            end
          end
        end
        if (have) begin
          o.found  = 1'b1;
          o.chosen = best[3:0];
        end
      end
      KIND_RAN: begin
        // ignored on empty slots, sticks at the top of the count
        if (tbl_valid[r.slot] && tbl_runs[r.slot] != 16'hFFFF)
          tbl_runs[r.slot] = tbl_runs[r.slot] + 16'd1;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void plan_row(input kind_t k, input logic [3:0] s, input logic [15:0] p,
                                   input logic [15:0] b, input logic [31:0] st,
                                   input bit pinned, input logic f, input logic [3:0] c);
    plan_row_t row;
    row.req.kind        = k;
    row.req.slot        = s;
    row.req.period      = p;
    row.req.budget      = b;
    row.req.spawn_stamp = st;
    row.pinned          = pinned;
    row.rsp.found       = f;
    row.rsp.chosen      = c;
    plan.push_back(row);
  endfunction

  // mostly small periods, budgets and stamps so that deadlines expire and
  // ties happen often; now and then a full-width value
  function automatic req_t random_request();
    req_t r;
    int   w;
    w = $urandom_range(0, 99);
    if (w < 22)      r.kind = KIND_ADD;
    else if (w < 45) r.kind = KIND_TICK;
    else if (w < 75) r.kind = KIND_SELECT;
    else             r.kind = KIND_RAN;
    r.slot        = 4'($urandom_range(0, 15));
    r.period      = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    r.budget      = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    r.spawn_stamp = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 3));
    return r;
  endfunction

  // sender pacing: bursts of back-to-back requests, random gaps in between
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        start   <= 1'b0;
        request <= req_t'({6'($urandom), $urandom, $urandom});
      end
    end
    burst_left--;
  endtask

  // hand one request over and record its expected answer once taken
  task automatic send(input req_t r, input bit pinned, input rsp_t pinned_rsp);
    rsp_t p;
    @(negedge clk);
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = schedule_step(r);
    expected_picks.push_back(pinned ? pinned_rsp : p);
    accepted++;
  endtask

  // result checker: every done pulse is matched against the oldest answer
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (expected_picks.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: found=%0b chosen=%0d", result.found, result.chosen);
      end else begin
        want = expected_picks.pop_front();
        if (result.found !== want.found || result.chosen !== want.chosen) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: expected found=%0b chosen=%0d, got found=%0b chosen=%0d",
                     want.found, want.chosen, result.found, result.chosen);
        end
        if (want.found) picks_found++;
      end
    end
  end

  // watchdog: too long without a request taken or a result delivered
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("edf_task_scheduler_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rsp_t none;
    int   i;

    none       = '0;
    accepted   = 0;
    burst_left = 0;
    for (i = 0; i < EDF_TASKS; i++) tbl_valid[i] = 1'b0;

    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed table
    plan_row(KIND_SELECT, 4'd0,  16'd0,      16'd0,      32'd0,          1, 1'b0, 4'd0);  // empty table
    plan_row(KIND_TICK,   4'd0,  16'd0,      16'd0,      32'd0,          1, 1'b0, 4'd0);
    plan_row(KIND_RAN,    4'd5,  16'd0,      16'd0,      32'd0,          1, 1'b0, 4'd0);  // empty slot
    plan_row(KIND_ADD,    4'd0,  16'd0,      16'd0,      32'd0,          1, 1'b0, 4'd0);
    plan_row(KIND_SELECT, 4'd0,  16'd0,      16'd0,      32'd0,          1, 1'b0, 4'd0);  // zero budget
    plan_row(KIND_ADD,    4'd15, 16'hFFFF,   16'hFFFF,   32'hFFFF_FFFF,  1, 1'b0, 4'd0);
    plan_row(KIND_SELECT, 4'd0,  16'd0,      16'd0,      32'd0,          1, 1'b1, 4'd15);
    plan_row(KIND_TICK,   4'd0,  16'd0,      16'd0,      32'd0,          1, 1'b0, 4'd0);
    plan_row(KIND_ADD,    4'd3,  16'd10,     16'd1,      32'd5,          1, 1'b0, 4'd0);
    plan_row(KIND_SELECT, 4'd0,  16'd0,      16'd0,      32'd0,          1, 1'b1, 4'd3);
    plan_row(KIND_RAN,    4'd3,  16'd0,      16'd0,      32'd0,          1, 1'b0, 4'd0);
    plan_row(KIND_SELECT, 4'd0,  16'd0,      16'd0,      32'd0,          1, 1'b1, 4'd15); // 3 spent
    plan_row(KIND_RAN,    4'd15, 16'd0,      16'd0,      32'd0,          1, 1'b0, 4'd0);
    plan_row(KIND_ADD,    4'd7,  16'd9,      16'd2,      32'd5,          1, 1'b0, 4'd0);
    plan_row(KIND_ADD,    4'd8,  16'd9,      16'd2,      32'd5,          1, 1'b0, 4'd0);
    plan_row(KIND_SELECT, 4'd0,  16'd0,      16'd0,      32'd0,          0, 1'b0, 4'd0);  // full tie
    plan_row(KIND_ADD,    4'd9,  16'd9,      16'd2,      32'd4,          1, 1'b0, 4'd0);
    plan_row(KIND_SELECT, 4'd0,  16'd0,      16'd0,      32'd0,          0, 1'b0, 4'd0);  // countdown tie
    plan_row(KIND_ADD,    4'd1,  16'd1,      16'd1,      32'd0,          1, 1'b0, 4'd0);
    plan_row(KIND_RAN,    4'd1,  16'd0,      16'd0,      32'd0,          1, 1'b0, 4'd0);
    plan_row(KIND_SELECT, 4'd0,  16'd0,      16'd0,      32'd0,          0, 1'b0, 4'd0);
    plan_row(KIND_TICK,   4'd0,  16'd0,      16'd0,      32'd0,          1, 1'b0, 4'd0);
    plan_row(KIND_TICK,   4'd0,  16'd0,      16'd0,      32'd0,          1, 1'b0, 4'd0);  // reload
    plan_row(KIND_SELECT, 4'd0,  16'd0,      16'd0,      32'd0,          0, 1'b0, 4'd0);
    plan_row(KIND_ADD,    4'd15, 16'd0,      16'd3,      32'd0,          1, 1'b0, 4'd0);  // replace

    foreach (plan[k]) begin
      pace();
      send(plan[k].req, plan[k].pinned, plan[k].rsp);
    end

    // random mix
    repeat (RANDOM_REQUESTS) begin
      pace();
      send(random_request(), 0, none);
    end

    @(negedge clk);
    start   <= 1'b0;
    request <= '0;

    while (expected_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests taken, %0d selects found a task; directed table",
             accepted, picks_found);
    $display("and random add/tick/select/ran traffic with sender gaps, %0d mismatches",
             mismatch_count);
    if (fail_count == 0) begin
      $display("edf_task_scheduler_test: PASS");
    end else begin
      $display("edf_task_scheduler_test: FAIL");
    end
    $finish;
  end

endmodule
